FILE: hw/rtl/ant_pkg.sv
package ant_pkg;

  localparam int ENTRIES = 16;
  localparam int SLOT_W  = $clog2(ENTRIES + 1);
  localparam int CNT_W   = $clog2(ENTRIES + 1);
  localparam int OUT_W   = 5;
  localparam int TIME_W  = 32;
  localparam int ID_W    = 32;

  localparam logic [TIME_W-1:0] TIMEOUT_RESET = TIME_W'(5000);
  localparam logic              MODE_SWEEP    = 1'b1;

  typedef enum logic [1:0] {
    ST_REFRESHED = 2'd0,
    ST_INSERTED  = 2'd1,
    ST_DROPPED   = 2'd2,
    ST_SWEPT     = 2'd3
  } status_t;

  // broadcast to every cell while an item scans
  typedef struct packed {
    logic              mode;
    logic [ID_W-1:0]   peer_id;
    logic [TIME_W-1:0] now_ms;
    logic [TIME_W-1:0] timeout;
  } req_t;

  // partial result handed from cell to cell
  typedef struct packed {
    logic              found;
    logic [SLOT_W-1:0] slot;
    logic              free_found;
    logic [SLOT_W-1:0] free_slot;
    logic [CNT_W-1:0]  expired;
    logic [CNT_W-1:0]  used;
  } chain_t;

  // insert write, decoded by slot in each cell
  typedef struct packed {
    logic              en;
    logic [SLOT_W-1:0] slot;
    logic [ID_W-1:0]   peer_id;
    logic [TIME_W-1:0] now_ms;
  } wr_t;

endpackage

FILE: hw/rtl/ant_cell.sv
module ant_cell
  import ant_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  input  logic [SLOT_W-1:0] index,
  input  req_t              req,
  input  wr_t               wr,
  input  logic              tok_in,
  input  chain_t            link_in,
  output logic              tok_out,
  output chain_t            link_out
);

  logic              used;
  logic [ID_W-1:0]   id;
  logic [TIME_W-1:0] last_seen;

  logic [TIME_W-1:0] age;
  logic              expire;
  logic              match;
  logic              used_after;
  chain_t            link_next;

  always_comb begin
    age        = req.now_ms - last_seen;
    expire     = used && (age > req.timeout);
    match      = used && (id == req.peer_id) && !link_in.found;
    used_after = (req.mode == MODE_SWEEP) ? (used && !expire) : used;

    link_next      = link_in;
    link_next.used = link_in.used + CNT_W'(used_after);
    if (req.mode == MODE_SWEEP) begin
      link_next.expired = link_in.expired + CNT_W'(expire);
    end else begin
      if (match) begin
        link_next.found = 1'b1;
        link_next.slot  = index;
      end
      if (!used && !link_in.free_found) begin
        link_next.free_found = 1'b1;
        link_next.free_slot  = index;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      used    <= 1'b0;
      tok_out <= 1'b0;
    end else begin
      tok_out <= tok_in;
      if (wr.en && wr.slot == index) begin
        used <= 1'b1;
      end else if (tok_in && req.mode == MODE_SWEEP && expire) begin
        used <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    link_out <= link_next;
    if (wr.en && wr.slot == index) begin
      id        <= wr.peer_id;
      last_seen <= wr.now_ms;
    end else if (tok_in) begin
      if (req.mode == MODE_SWEEP && expire) begin
        id        <= '0;
        last_seen <= '0;
      end else if (req.mode != MODE_SWEEP && match) begin
        last_seen <= req.now_ms;
      end
    end
  end

endmodule

FILE: hw/rtl/aging_neighbor_table.sv
// Table of ENTRIES peer identifiers with last-heard times, held in a row of
// cells. An item is passed down the row one cell per cycle; in_stall stays
// high during that scan. The result goes to an output register, so a new
// word can be scanned while the previous result waits. A note refreshes a
// matching entry or inserts into the lowest free entry at the end of the
// scan, or is dropped if none is free; a sweep frees entries older than the
// timeout register. cfg_ready is always high; write the timeout only idle.
module aging_neighbor_table
  import ant_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_stall,
  input  logic              mode,
  input  logic [ID_W-1:0]   peer_id,
  input  logic [TIME_W-1:0] now_ms,
  output logic              out_valid,
  input  logic              out_stall,
  output logic [1:0]        status,
  output logic [OUT_W-1:0]  slot,
  output logic [OUT_W-1:0]  expired_count,
  output logic [OUT_W-1:0]  used_count,
  input  logic              cfg_valid,
  output logic              cfg_ready,
  input  logic [TIME_W-1:0] cfg_data
);

  logic              scanning;
  logic              launch;
  logic              res_pend;
  status_t           res_status;
  logic [SLOT_W-1:0] res_slot;
  logic [CNT_W-1:0]  res_expired;
  logic [CNT_W-1:0]  res_used;
  req_t              req;

  logic              tok  [ENTRIES+1];
  chain_t            link [ENTRIES+1];
  wr_t               wr;
  chain_t            tail;
  logic              tail_valid;
  logic              in_take;
  logic              out_load;

  status_t           tail_status;
  logic [SLOT_W-1:0] tail_slot;
  logic [CNT_W-1:0]  tail_used;

  assign cfg_ready = 1'b1;
  assign in_stall  = scanning || res_pend;
  assign in_take   = in_valid && !in_stall;
  assign out_load  = res_pend && (!out_valid || !out_stall);

  assign tok[0]     = launch;
  assign link[0]    = '0;
  assign tail       = link[ENTRIES];
  assign tail_valid = tok[ENTRIES];

  for (genvar k = 0; k < ENTRIES; k++) begin : g_cell
    ant_cell u_cell (
      .clk      (clk),
      .rst      (rst),
      .index    (SLOT_W'(k)),
      .req      (req),
      .wr       (wr),
      .tok_in   (tok[k]),
      .link_in  (link[k]),
      .tok_out  (tok[k+1]),
      .link_out (link[k+1])
    );
  end

  always_comb begin
    wr         = '0;
    wr.slot    = tail.free_slot;
    wr.peer_id = req.peer_id;
    wr.now_ms  = req.now_ms;
    tail_slot  = SLOT_W'(ENTRIES);
    tail_used  = tail.used;
    if (req.mode == MODE_SWEEP) begin
      tail_status = ST_SWEPT;
    end else if (tail.found) begin
      tail_status = ST_REFRESHED;
      tail_slot   = tail.slot;
    end else if (tail.free_found) begin
      tail_status = ST_INSERTED;
      tail_slot   = tail.free_slot;
      tail_used   = tail.used + CNT_W'(1);
      wr.en       = tail_valid;
    end else begin
      tail_status = ST_DROPPED;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      scanning    <= 1'b0;
      launch      <= 1'b0;
      res_pend    <= 1'b0;
      out_valid   <= 1'b0;
      req.timeout <= TIMEOUT_RESET;
    end else begin
      launch <= in_take;
      if (cfg_valid && cfg_ready) begin
        req.timeout <= cfg_data;
      end
      if (in_take) begin
        scanning    <= 1'b1;
        req.mode    <= mode;
        req.peer_id <= peer_id;
        req.now_ms  <= now_ms;
      end else if (tail_valid) begin
        scanning <= 1'b0;
      end
      if (tail_valid) begin
        res_pend <= 1'b1;
      end else if (out_load) begin
        res_pend <= 1'b0;
      end
      if (out_load) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (tail_valid) begin
      res_status  <= tail_status;
      res_slot    <= tail_slot;
      res_expired <= (req.mode == MODE_SWEEP) ? tail.expired : '0;
      res_used    <= tail_used;
    end
    if (out_load) begin
      status        <= res_status;
      slot          <= OUT_W'(res_slot);
      expired_count <= OUT_W'(res_expired);
      used_count    <= OUT_W'(res_used);
    end
  end

  a_tail_in_scan: assert property (@(posedge clk) disable iff (rst)
    tail_valid |-> scanning)
    else $error("scan result without a scan in flight");

  a_take_starts_scan: assert property (@(posedge clk) disable iff (rst)
    in_take |=> scanning && launch)
    else $error("accepted word did not start a scan");

  a_used_bound: assert property (@(posedge clk) disable iff (rst)
    res_pend |-> res_used <= CNT_W'(ENTRIES))
    else $error("used count above table size");

  a_insert_slot: assert property (@(posedge clk) disable iff (rst)
    res_pend && (res_status == ST_INSERTED || res_status == ST_REFRESHED)
      |-> res_slot < SLOT_W'(ENTRIES))
    else $error("touched slot out of range");

  a_no_write_on_sweep: assert property (@(posedge clk) disable iff (rst)
    wr.en |-> req.mode != MODE_SWEEP && !tail.found)
    else $error("insert write on sweep or matched note");

endmodule

FILE: bench/aging_neighbor_table_tb.sv
`timescale 1ns / 1ps

module aging_neighbor_table_tb;
  import ant_pkg::*;

  localparam int LIMIT = 400000;
  localparam int MAX_SHOWN = 100;
  localparam logic MODE_NOTE = ~MODE_SWEEP;

  typedef struct {
    logic [1:0]       status;
    logic [OUT_W-1:0] slot;
    logic [OUT_W-1:0] expired;
    logic [OUT_W-1:0] used;
  } table_result_t;

  logic              clk;
  logic              rst;
  logic              in_valid;
  logic              in_stall;
  logic              mode;
  logic [ID_W-1:0]   peer_id;
  logic [TIME_W-1:0] now_ms;
  logic              out_valid;
  logic              out_stall;
  logic [1:0]        status;
  logic [OUT_W-1:0]  slot;
  logic [OUT_W-1:0]  expired_count;
  logic [OUT_W-1:0]  used_count;
  logic              cfg_valid;
  logic              cfg_ready;
  logic [TIME_W-1:0] cfg_data;

  // predictor copy of the table
  logic [ID_W-1:0]   tbl_id   [ENTRIES];
  logic [TIME_W-1:0] tbl_seen [ENTRIES];
  logic              tbl_used [ENTRIES];
  logic [TIME_W-1:0] timeout_reg;

  table_result_t pending_results[$];

  int idle_pct;
  int stall_pct;
  int errors;
  int cycles;
  int n_results;
  int n_notes;
  int n_sweeps;
  int n_inserts;
  int n_refreshes;
  int n_drops;
  int n_expired;
  int n_cfg;

  aging_neighbor_table dut (
    .clk           (clk),
    .rst           (rst),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .mode          (mode),
    .peer_id       (peer_id),
    .now_ms        (now_ms),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .status        (status),
    .slot          (slot),
    .expired_count (expired_count),
    .used_count    (used_count),
    .cfg_valid     (cfg_valid),
    .cfg_ready     (cfg_ready),
    .cfg_data      (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  always @(negedge clk) begin
    out_stall <= ($urandom_range(99) < stall_pct);
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles >= LIMIT) begin
      $display("timeout after %0d cycles, %0d results pending", cycles,
               pending_results.size());
      $display("*** FAILED ***");
      $finish;
    end
  end

  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
    errors++;
    if (errors <= MAX_SHOWN)
      $display("mismatch at cycle %0d: %s got %0h want %0h", cycles, what, got, want);
  endtask

  always @(posedge clk) begin
    table_result_t want;
    if (!rst && out_valid && !out_stall) begin
      n_results++;
      if (pending_results.size() == 0) begin
        report_mismatch("result word with none pending", 32'd1, 32'd0);
      end else begin
        want = pending_results.pop_front();
        if (status !== want.status)
          report_mismatch("status", 32'(status), 32'(want.status));
        if (slot !== want.slot) report_mismatch("slot", 32'(slot), 32'(want.slot));
        if (expired_count !== want.expired)
          report_mismatch("expired_count", 32'(expired_count), 32'(want.expired));
        if (used_count !== want.used)
          report_mismatch("used_count", 32'(used_count), 32'(want.used));
      end
    end
  end

  task automatic predict_result(input logic m, input logic [ID_W-1:0] id,
                                input logic [TIME_W-1:0] now, output table_result_t r);
    int hit;
    int in_use;
    logic [TIME_W-1:0] age;
    r.status  = ST_DROPPED;
    r.slot    = OUT_W'(ENTRIES);
    r.expired = '0;
    if (m == MODE_SWEEP) begin
      n_sweeps++;
      r.status = ST_SWEPT;
      for (int k = 0; k < ENTRIES; k++) begin
        if (tbl_used[k]) begin
          age = now - tbl_seen[k];
          if (age > timeout_reg) begin
            tbl_used[k] = 1'b0;
            tbl_id[k]   = '0;
            tbl_seen[k] = '0;
            r.expired   = r.expired + 1'b1;
            n_expired++;
          end
        end
      end
    end else begin
      n_notes++;
      hit = -1;
      for (int k = 0; k < ENTRIES; k++)
        if (hit < 0 && tbl_used[k] && tbl_id[k] == id) hit = k;
      if (hit >= 0) begin
        tbl_seen[hit] = now;
        r.status = ST_REFRESHED;
        r.slot   = OUT_W'(hit);
        n_refreshes++;
      end else begin
        for (int k = 0; k < ENTRIES; k++) begin
          if (hit < 0 && !tbl_used[k]) begin
            hit         = k;
            tbl_used[k] = 1'b1;
            tbl_id[k]   = id;
            tbl_seen[k] = now;
            r.status    = ST_INSERTED;
            r.slot      = OUT_W'(k);
          end
        end
        if (hit >= 0) n_inserts++;
        else n_drops++;
      end
    end
    in_use = 0;
    for (int k = 0; k < ENTRIES; k++)
      if (tbl_used[k]) in_use++;
    r.used = OUT_W'(in_use);
  endtask

  task automatic send_word(input logic m, input logic [ID_W-1:0] id,
                           input logic [TIME_W-1:0] now);
    table_result_t r;
    @(negedge clk);
    while ($urandom_range(99) < idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    mode     <= m;
    peer_id  <= id;
    now_ms   <= now;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    predict_result(m, id, now, r);
    pending_results.push_back(r);
  endtask

  task automatic wait_drain();
    @(negedge clk);
    in_valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (ENTRIES + 6) @(posedge clk);
  endtask

  task automatic write_timeout(input logic [TIME_W-1:0] value);
    wait_drain();
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_data  <= value;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    timeout_reg = value;
    n_cfg++;
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  // reset timeout; refresh, wraparound age and the strict-greater boundary
  task automatic test_insert_refresh();
    idle_pct  = 0;
    stall_pct = 0;
    send_word(MODE_NOTE, 32'h0000_0000, 32'h0000_0000);
    send_word(MODE_NOTE, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    send_word(MODE_NOTE, 32'h0000_0000, 32'd100);
    send_word(MODE_SWEEP, 32'hFFFF_FFFF, 32'd5000);
    send_word(MODE_NOTE, 32'hFFFF_FFFF, 32'd5000);
    send_word(MODE_SWEEP, 32'h0000_0000, 32'd5100);
    send_word(MODE_SWEEP, 32'h0000_0000, 32'd5101);
  endtask

  task automatic test_table_full();
    for (int k = 0; k < ENTRIES; k++)
      send_word(MODE_NOTE, 32'h1000_0000 + k, 32'd6000);
    send_word(MODE_NOTE, 32'hFFFF_FFFF, 32'd5990);
    send_word(MODE_NOTE, 32'h0000_0000, 32'd6000);
  endtask

  task automatic test_sweep_timeouts();
    write_timeout(32'h0000_0000);
    send_word(MODE_SWEEP, 32'h0000_0000, 32'd6000);
    write_timeout(32'hFFFF_FFFF);
    send_word(MODE_SWEEP, 32'hFFFF_FFFF, 32'd0);
    write_timeout(32'd1);
    send_word(MODE_SWEEP, 32'h0000_0000, 32'd6002);
  endtask

  task automatic test_random_traffic(input int sender_idle, input int recv_stall,
                                     input logic [TIME_W-1:0] tmo,
                                     input logic [TIME_W-1:0] t0, input int count);
    logic [ID_W-1:0]   pool [32];
    int                pool_n;
    int                pick;
    logic [TIME_W-1:0] clock_ms;
    write_timeout(tmo);
    idle_pct  = sender_idle;
    stall_pct = recv_stall;
    pool_n    = $urandom_range(8, 28);
    for (int k = 0; k < 32; k++) pool[k] = $urandom;
    clock_ms = t0;
    for (int i = 0; i < count; i++) begin
      if (i == count / 2) wait_drain();
      pick = $urandom_range(99);
      if (pick < 10) begin
        send_word(1'($urandom_range(1)), $urandom, $urandom);
      end else begin
        if ($urandom_range(3) != 0) clock_ms = clock_ms + $urandom_range(1, 600);
        if (pick < 22) send_word(MODE_SWEEP, $urandom, clock_ms);
        else send_word(MODE_NOTE, pool[$urandom_range(pool_n - 1)], clock_ms);
      end
    end
  endtask

  initial begin
    rst       = 1'b1;
    in_valid  = 1'b0;
    mode      = 1'b0;
    peer_id   = '0;
    now_ms    = '0;
    cfg_valid = 1'b0;
    cfg_data  = '0;
    idle_pct  = 0;
    stall_pct = 0;
    timeout_reg = TIMEOUT_RESET;
    for (int k = 0; k < ENTRIES; k++) begin
      tbl_id[k]   = '0;
      tbl_seen[k] = '0;
      tbl_used[k] = 1'b0;
    end
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    test_insert_refresh();
    test_table_full();
    test_sweep_timeouts();
    test_random_traffic(0, 0, 32'd2000, 32'hFFFF_F000, 356);
    test_random_traffic(88, 0, 32'h0000_0000, $urandom, 356);
    test_random_traffic(0, 88, 32'hFFFF_FFFF, $urandom, 356);
    test_random_traffic(35, 35, $urandom_range(300, 3000), $urandom, 356);
    wait_drain();

    $display("covered %0d notes (%0d inserted, %0d refreshed, %0d dropped), %0d sweeps",
             n_notes, n_inserts, n_refreshes, n_drops, n_sweeps);
    $display("%0d entries aged out, %0d timeout writes, %0d results checked, %0d mismatches",
             n_expired, n_cfg, n_results, errors);
    if (errors == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule

FILE: files.f
hw/rtl/ant_pkg.sv
hw/rtl/ant_cell.sv
hw/rtl/aging_neighbor_table.sv
bench/aging_neighbor_table_tb.sv
